// ----- design/rem_pkg.sv -----
// Shared types and constants for the regression error metrics block.
// Used by rem_ctrl, rem_datapath and regression_error_metrics; depends on nothing.

package rem_pkg;

  // Field and state widths.
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 17;
  localparam int ABS_W   = 32;
  localparam int SUM_W   = 48;
  localparam int MEAN_W  = 32;
  localparam int STEP_W  = 6;

  // Largest number of pairs that one set counts.
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 17'd65536;

  // Clip limits for the ratio and for the means.
  localparam logic [SUM_W-1:0] RATIO_MAX = 48'h0000_FFFF_0000;
  localparam logic [SUM_W-1:0] MSE_MAX   = 48'd4294836225;
  localparam logic [MEAN_W-1:0] RATIO_MAX32 = 32'hFFFF_0000;
  localparam logic [MEAN_W-1:0] MSE_MAX32   = 32'd4294836225;

  // Last step index of each divider mode, and the square root step count.
  localparam logic [STEP_W-1:0] DIV32_LAST = 6'd31;
  localparam logic [STEP_W-1:0] DIV48_LAST = 6'd47;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd16;

  // Which operands the shared divider loads.
  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_ABS,
    DIV_SQ,
    DIV_PCT
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     load_acc;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     acc_final;
    logic     store_mae;
    logic     store_mse;
    logic     sqrt_step;
    logic     store_final;
  } rem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_zero;
    logic last;
  } rem_status_t;

endpackage

// ----- design/rem_datapath.sv -----
// Datapath of the regression error metrics block: sums, count, shared divider,
// square root unit and output registers. Depends on rem_pkg.

module rem_datapath import rem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rem_cmd_t                 cmd,
  output rem_status_t              status,
  input  logic signed [VAL_W-1:0]  in_true_value,
  input  logic signed [VAL_W-1:0]  in_pred_value,
  input  logic                     in_last,
  output logic [CNT_W-1:0]         out_sample_count,
  output logic [VAL_W-1:0]         out_mean_abs_error,
  output logic [MEAN_W-1:0]        out_mean_sq_error,
  output logic [VAL_W-1:0]         out_root_mean_sq_error,
  output logic [MEAN_W-1:0]        out_mean_abs_pct_error,
  output logic                     out_overflow
);

  // Captured pair.
  logic [VAL_W-1:0]    ad_r;
  logic [VAL_W-1:0]    at_r;
  logic                last_r;
  logic [2*VAL_W-1:0]  sq_r;

  // Running sums and count.
  logic [ABS_W-1:0]    abs_sum_r;
  logic [SUM_W-1:0]    sq_sum_r;
  logic [SUM_W-1:0]    pct_sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                sat_r;

  // Divider.
  logic [SUM_W-1:0]    div_q_r;
  logic [CNT_W-1:0]    div_rem_r;
  logic [CNT_W-1:0]    div_den_r;

  // Square root unit.
  logic [MEAN_W-1:0]   sqrt_v_r;
  logic [CNT_W-1:0]    sqrt_rem_r;
  logic [VAL_W-1:0]    sqrt_root_r;

  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        abs_diff;
  logic [VAL_W:0]        abs_true;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_sub;
  logic                  div_ge;
  logic [CNT_W+1:0]      sqrt_sh;
  logic [CNT_W+1:0]      sqrt_trial;
  logic                  sqrt_ge;
  logic [ABS_W:0]        abs_add;
  logic [SUM_W:0]        sq_add;
  logic [SUM_W:0]        pct_add;
  logic                  sat_set;
  logic [MEAN_W-1:0]     mse_clip;
  logic [MEAN_W-1:0]     mape_clip;

  // Difference and magnitudes of the incoming pair.
  always_comb begin
    diff     = VAL_W'(0) + ({in_true_value[VAL_W-1], in_true_value}
               - {in_pred_value[VAL_W-1], in_pred_value});
    abs_diff = diff[VAL_W] ? (~diff + 1'b1) : diff;
    abs_true = in_true_value[VAL_W-1] ?
               (~{1'b1, in_true_value} + 1'b1) : {1'b0, in_true_value};
  end

  // One restoring divider step.
  always_comb begin
    rem_sh  = {div_rem_r, div_q_r[SUM_W-1]};
    div_ge  = rem_sh >= {1'b0, div_den_r};
    rem_sub = rem_sh - {1'b0, div_den_r};
  end

  // One square root step, two radicand bits at a time.
  always_comb begin
    sqrt_sh    = {sqrt_rem_r, sqrt_v_r[MEAN_W-1 -: 2]};
    sqrt_trial = {1'b0, sqrt_root_r, 2'b01};
    sqrt_ge    = sqrt_sh >= sqrt_trial;
  end

  // Saturating sums.
  always_comb begin
    abs_add = {1'b0, abs_sum_r} + {{(ABS_W-VAL_W+1){1'b0}}, ad_r};
    sq_add  = {1'b0, sq_sum_r} + {{(SUM_W-2*VAL_W+1){1'b0}}, sq_r};
    pct_add = {1'b0, pct_sum_r} + {{(SUM_W-MEAN_W+1){1'b0}}, div_q_r[MEAN_W-1:0]};
  end

  // The set overflows when a sum clips or a pair arrives with the count full.
  always_comb begin
    sat_set = 1'b0;
    if (cmd.load_acc && (abs_add[ABS_W] || (cnt_r == MAX_SAMPLES))) begin
      sat_set = 1'b1;
    end
    if (cmd.acc_final && (sq_add[SUM_W] || (!(at_r == '0) && pct_add[SUM_W]))) begin
      sat_set = 1'b1;
    end
  end

  // Clipped means from the quotient.
  always_comb begin
    mse_clip  = (div_q_r > MSE_MAX)   ? MSE_MAX32   : div_q_r[MEAN_W-1:0];
    mape_clip = (div_q_r > RATIO_MAX) ? RATIO_MAX32 : div_q_r[MEAN_W-1:0];
  end

  // Pair capture and the squared error.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ad_r   <= abs_diff[VAL_W-1:0];
      at_r   <= abs_true[VAL_W-1:0];
      last_r <= in_last;
    end
    if (cmd.load_acc) begin
      sq_r <= ad_r * ad_r;
    end
  end

  // Sums, count and overflow flag; cleared once a result is stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_sum_r <= '0;
      sq_sum_r  <= '0;
      pct_sum_r <= '0;
      cnt_r     <= '0;
      sat_r     <= 1'b0;
    end else if (cmd.store_final) begin
      abs_sum_r <= '0;
      sq_sum_r  <= '0;
      pct_sum_r <= '0;
      cnt_r     <= '0;
      sat_r     <= 1'b0;
    end else begin
      if (sat_set) begin
        sat_r <= 1'b1;
      end
      if (cmd.load_acc) begin
        if (abs_add[ABS_W]) begin
          abs_sum_r <= '1;
        end else begin
          abs_sum_r <= abs_add[ABS_W-1:0];
        end
        if (cnt_r != MAX_SAMPLES) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.acc_final) begin
        if (sq_add[SUM_W]) begin
          sq_sum_r <= '1;
        end else begin
          sq_sum_r <= sq_add[SUM_W-1:0];
        end
        // The ratio never exceeds its clip limit, so the quotient is added as is.
        if (!(at_r == '0)) begin
          if (pct_add[SUM_W]) begin
            pct_sum_r <= '1;
          end else begin
            pct_sum_r <= pct_add[SUM_W-1:0];
          end
        end
      end
    end
  end

  // Shared divider: load operands, then one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem_r <= '0;
      unique case (cmd.div_sel)
        DIV_RATIO: begin
          div_q_r   <= {ad_r, {(SUM_W-VAL_W){1'b0}}};
          div_den_r <= {1'b0, at_r};
        end
        DIV_ABS: begin
          div_q_r   <= {abs_sum_r, {(SUM_W-ABS_W){1'b0}}};
          div_den_r <= cnt_r;
        end
        DIV_SQ: begin
          div_q_r   <= sq_sum_r;
          div_den_r <= cnt_r;
        end
        DIV_PCT: begin
          div_q_r   <= pct_sum_r;
          div_den_r <= cnt_r;
        end
        default: begin
          div_q_r   <= '0;
          div_den_r <= cnt_r;
        end
      endcase
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      div_q_r   <= {div_q_r[SUM_W-2:0], div_ge};
    end
  end

  // Square root: loaded with the clipped mean squared error.
  always_ff @(posedge clk) begin
    if (cmd.store_mse) begin
      sqrt_v_r    <= mse_clip;
      sqrt_rem_r  <= '0;
      sqrt_root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sqrt_v_r    <= {sqrt_v_r[MEAN_W-3:0], 2'b00};
      sqrt_rem_r  <= sqrt_ge ? CNT_W'(sqrt_sh - sqrt_trial) : sqrt_sh[CNT_W-1:0];
      sqrt_root_r <= {sqrt_root_r[VAL_W-2:0], sqrt_ge};
    end
  end

  // Output registers, written only while the output is empty.
  always_ff @(posedge clk) begin
    if (cmd.store_mae) begin
      out_mean_abs_error <= (div_q_r[MEAN_W-1:VAL_W] != '0) ? '1 : div_q_r[VAL_W-1:0];
    end
    if (cmd.store_mse) begin
      out_mean_sq_error <= mse_clip;
    end
    if (cmd.store_final) begin
      out_mean_abs_pct_error <= mape_clip;
      out_root_mean_sq_error <= sqrt_root_r;
      out_sample_count       <= cnt_r;
      out_overflow           <= sat_r;
    end
  end

  assign status.at_zero = (at_r == '0);
  assign status.last    = last_r;

endmodule

// ----- design/rem_ctrl.sv -----
// Controller of the regression error metrics block: sequences capture,
// accumulation, divisions and the square root. Depends on rem_pkg.

module rem_ctrl import rem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  rem_status_t status,
  output rem_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RATIO,
    ST_ACCUM,
    ST_WAIT,
    ST_MAE,
    ST_MAE_ST,
    ST_MSE,
    ST_MSE_ST,
    ST_MAPE,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_r  <= '0;
          state_r <= status.at_zero ? ST_ACCUM : ST_RATIO;
        end
        ST_RATIO: begin
          step_r <= step_r + 1'b1;
          if (step_r == DIV32_LAST) begin
            state_r <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          state_r <= status.last ? ST_WAIT : ST_IDLE;
        end
        ST_WAIT: begin
          step_r <= '0;
          if (!out_valid_r) begin
            state_r <= ST_MAE;
          end
        end
        ST_MAE: begin
          step_r <= step_r + 1'b1;
          if (step_r == DIV32_LAST) begin
            state_r <= ST_MAE_ST;
          end
        end
        ST_MAE_ST: begin
          step_r  <= '0;
          state_r <= ST_MSE;
        end
        ST_MSE: begin
          step_r <= step_r + 1'b1;
          if (step_r == DIV48_LAST) begin
            state_r <= ST_MSE_ST;
          end
        end
        ST_MSE_ST: begin
          step_r  <= '0;
          state_r <= ST_MAPE;
        end
        ST_MAPE: begin
          step_r <= step_r + 1'b1;
          if (step_r == DIV48_LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd             = '0;
    cmd.div_sel     = DIV_RATIO;
    unique case (state_r)
      ST_IDLE:   cmd.capture = in_valid && rst_n;
      ST_LOAD: begin
        cmd.load_acc = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_RATIO;
      end
      ST_RATIO:  cmd.div_step = 1'b1;
      ST_ACCUM:  cmd.acc_final = 1'b1;
      ST_WAIT: begin
        cmd.div_load = !out_valid_r;
        cmd.div_sel  = DIV_ABS;
      end
      ST_MAE:    cmd.div_step = 1'b1;
      ST_MAE_ST: begin
        cmd.store_mae = 1'b1;
        cmd.div_load  = 1'b1;
        cmd.div_sel   = DIV_SQ;
      end
      ST_MSE:    cmd.div_step = 1'b1;
      ST_MSE_ST: begin
        cmd.store_mse = 1'b1;
        cmd.div_load  = 1'b1;
        cmd.div_sel   = DIV_PCT;
      end
      // The square root runs alongside the first steps of the last division.
      ST_MAPE: begin
        cmd.div_step  = 1'b1;
        cmd.sqrt_step = step_r < SQRT_STEPS;
      end
      ST_DONE:   cmd.store_final = 1'b1;
      default:   cmd = '0;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  // The result is stored only while the output register is empty.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !out_valid_r)
    else $error("result stored while output register still full");

  // A new output word appears only after a finished set.
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("output valid raised outside the done state");

  // An accepted word always starts the load step.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD))
    else $error("accepted word did not start processing");

  // The step counter never runs past the widest division.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= DIV48_LAST + 1'b1)
    else $error("step counter out of range");
`endif

endmodule

// ----- design/regression_error_metrics.sv -----
// Top level of the regression error metrics block: controller plus datapath.
// Depends on rem_pkg, rem_ctrl and rem_datapath.

// Takes (true, predicted) Q8.8 pairs and, on the word marked last, returns the
// count, MAE, MSE, RMSE and MAPE of the set, then starts a new set. A new pair
// is accepted only once the previous one is through. The shared restoring
// divider produces one quotient bit per cycle for the 32-bit percentage ratio,
// which is skipped when the true value is zero. A last pair adds the three mean
// divisions (32, 48 and 48 steps, the square root running beside the last one),
// plus any wait for the previous result to leave the output register. Results
// in the output register do not block acceptance of further pairs.

module regression_error_metrics import rem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VAL_W-1:0]  in_true_value,
  input  logic signed [VAL_W-1:0]  in_pred_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CNT_W-1:0]         out_sample_count,
  output logic [VAL_W-1:0]         out_mean_abs_error,
  output logic [MEAN_W-1:0]        out_mean_sq_error,
  output logic [VAL_W-1:0]         out_root_mean_sq_error,
  output logic [MEAN_W-1:0]        out_mean_abs_pct_error,
  output logic                     out_overflow
);

  rem_cmd_t    cmd;
  rem_status_t status;

  // Sequencer.
  rem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  rem_datapath u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_true_value          (in_true_value),
    .in_pred_value          (in_pred_value),
    .in_last                (in_last),
    .out_sample_count       (out_sample_count),
    .out_mean_abs_error     (out_mean_abs_error),
    .out_mean_sq_error      (out_mean_sq_error),
    .out_root_mean_sq_error (out_root_mean_sq_error),
    .out_mean_abs_pct_error (out_mean_abs_pct_error),
    .out_overflow           (out_overflow)
  );

endmodule
